### hdl/touch_gesture_classifier_macros.svh
// Assertion macros shared by the touch gesture classifier RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGC_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/tgc_pkg.sv
// Shared types, codes and constants of the touch gesture classifier.
// Used by tgc_decide and touch_gesture_classifier; depends on nothing.
package tgc_pkg;

    // Field widths.
    localparam int COORD_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int TYPE_WIDTH  = 5;
    localparam int CODE_WIDTH  = 10;
    localparam int VALUE_WIDTH = 16;
    localparam int GESTURE_W   = 4;
    localparam int CFG_IDX_W   = 3;
    // Signed working width: holds a register minus a register, and twice an offset.
    localparam int CALC_W      = CFG_WIDTH + 2;

    // Event types and codes.
    localparam logic [TYPE_WIDTH-1:0] EVT_SYN = 5'd0;
    localparam logic [TYPE_WIDTH-1:0] EVT_KEY = 5'd1;
    localparam logic [TYPE_WIDTH-1:0] EVT_ABS = 5'd3;
    localparam logic [CODE_WIDTH-1:0] CODE_ABS_X      = 10'd0;
    localparam logic [CODE_WIDTH-1:0] CODE_ABS_Y      = 10'd1;
    localparam logic [CODE_WIDTH-1:0] CODE_BTN_TOUCH  = 10'd330;
    localparam logic [CODE_WIDTH-1:0] CODE_SYN_REPORT = 10'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DISP_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_RADIUS      = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [CFG_WIDTH-1:0] RST_DISP_WIDTH      = 16'd800;
    localparam logic [CFG_WIDTH-1:0] RST_DISP_HEIGHT     = 16'd480;
    localparam logic [CFG_WIDTH-1:0] RST_CORNER_SIZE     = 16'd120;
    localparam logic [CFG_WIDTH-1:0] RST_SWIPE_THRESHOLD = 16'd50;
    localparam logic [CFG_WIDTH-1:0] RST_TAP_RADIUS      = 16'd10;

    // Gesture codes.
    typedef enum logic [GESTURE_W-1:0] {
        G_NONE          = 4'd0,
        G_HOME          = 4'd1,
        G_PREV          = 4'd2,
        G_NEXT          = 4'd3,
        G_PAUSE         = 4'd4,
        G_SPEED_UP      = 4'd5,
        G_SPEED_DOWN    = 4'd6,
        G_VOL_UP        = 4'd7,
        G_VOL_DOWN      = 4'd8,
        G_TAP_OUTSIDE   = 4'd9,
        G_SWIPE_IGNORED = 4'd10
    } gesture_t;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] disp_width;
        logic [CFG_WIDTH-1:0] disp_height;
        logic [CFG_WIDTH-1:0] corner_size;
        logic [CFG_WIDTH-1:0] swipe_threshold;
        logic [CFG_WIDTH-1:0] tap_radius;
    } cfg_t;

    // Touch position pair handed to the classifier.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
    } point_t;

endpackage

### hdl/tgc_decide.sv
// Combinational tap and swipe decision for one touch release.
// Depends on tgc_pkg.
module tgc_decide (
    input  tgc_pkg::cfg_t     cfg,
    input  tgc_pkg::point_t   origin,
    input  tgc_pkg::point_t   release_pt,
    input  logic              playing,
    output tgc_pkg::gesture_t gesture
);
    import tgc_pkg::*;

    logic signed [CALC_W-1:0] sx, sy, ex, ey;
    logic signed [CALC_W-1:0] c, rx, by, th, rad;
    logic signed [CALC_W-1:0] dx, dy, ax, ay, ax2, ay2;
    logic is_tap, horiz, vert, middle;
    gesture_t tap_g, swipe_g;

    // Zero-extend everything into the common signed working width.
    assign sx  = signed'({{(CALC_W-COORD_WIDTH){1'b0}}, origin.x});
    assign sy  = signed'({{(CALC_W-COORD_WIDTH){1'b0}}, origin.y});
    assign ex  = signed'({{(CALC_W-COORD_WIDTH){1'b0}}, release_pt.x});
    assign ey  = signed'({{(CALC_W-COORD_WIDTH){1'b0}}, release_pt.y});
    assign c   = signed'({{(CALC_W-CFG_WIDTH){1'b0}}, cfg.corner_size});
    assign th  = signed'({{(CALC_W-CFG_WIDTH){1'b0}}, cfg.swipe_threshold});
    assign rad = signed'({{(CALC_W-CFG_WIDTH){1'b0}}, cfg.tap_radius});
    assign rx  = signed'({{(CALC_W-CFG_WIDTH){1'b0}}, cfg.disp_width}) - c;
    assign by  = signed'({{(CALC_W-CFG_WIDTH){1'b0}}, cfg.disp_height}) - c;

    // Travel from the press point and its magnitudes.
    assign dx  = ex - sx;
    assign dy  = ey - sy;
    assign ax  = (dx < 0) ? -dx : dx;
    assign ay  = (dy < 0) ? -dy : dy;
    assign ax2 = ax <<< 1;
    assign ay2 = ay <<< 1;

    assign is_tap = (ax < rad) && (ay < rad);
    assign horiz  = (ax > th) && (ax > ay2);
    assign vert   = (ay > th) && (ay > ax2);
    assign middle = (sx >= c) && (sx <= rx) && (sy >= c) && (sy <= by);

    // Corner zones, checked in priority order.
    always_comb
    begin
        if (sx < c && sy < c)
            tap_g = G_HOME;
        else if (sx < c && sy > by)
            tap_g = G_PREV;
        else if (sx > rx && sy > by)
            tap_g = G_NEXT;
        else if (sx > rx && sy < c)
            tap_g = playing ? G_PAUSE : G_NONE;
        else
            tap_g = G_TAP_OUTSIDE;
    end

    // Swipe direction; a horizontal swipe must begin in the middle region.
    always_comb
    begin
        if (horiz)
            swipe_g = !middle ? G_SWIPE_IGNORED : ((dx > 0) ? G_SPEED_UP : G_SPEED_DOWN);
        else if (vert)
            swipe_g = (dy < 0) ? G_VOL_UP : G_VOL_DOWN;
        else
            swipe_g = G_SWIPE_IGNORED;
    end

    // Swipes only count while playing.
    always_comb
    begin
        if (is_tap)
            gesture = tap_g;
        else if (playing)
            gesture = swipe_g;
        else
            gesture = G_SWIPE_IGNORED;
    end

endmodule

### hdl/touch_gesture_classifier.sv
// Touch gesture classifier: top level with event register, touch state and result register.
// Depends on tgc_pkg, tgc_decide and touch_gesture_classifier_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one touch event per request:
//   event_type, event_code, event_value and the playing flag.
//   Output channel (out_valid / out_stall) returns one result per event:
//   the gesture code (zero for everything but a classified release) and
//   touch_down, the pressed flag after that event.
//   The configuration channel (cfg_valid / cfg_ready, always ready) writes
//   one register per request: index 0 screen width, 1 screen height,
//   2 corner size, 3 swipe threshold, 4 tap radius; other indexes are dropped.
//   An accepted event passes through the event register and then the result
//   register before out_valid rises; one event is taken every cycle while in_stall is low.
//   A stalled result holds in the output register; the event register keeps
//   accepting until it too is full, then in_stall rises.
//   Reset clears the pressed flag and positions, loads the default screen
//   geometry (800 x 480, corner 120, threshold 50, tap radius 10) and
//   empties both stages.
module touch_gesture_classifier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tgc_pkg::TYPE_WIDTH-1:0]   event_type,
    input  logic [tgc_pkg::CODE_WIDTH-1:0]   event_code,
    input  logic [tgc_pkg::VALUE_WIDTH-1:0]  event_value,
    input  logic                             playing,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tgc_pkg::GESTURE_W-1:0]    gesture,
    output logic                             touch_down,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgc_pkg::CFG_WIDTH-1:0]    cfg_data
);
    import tgc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic                   in_vld_reg, in_vld_next;
    logic [TYPE_WIDTH-1:0]  type_reg;
    logic [CODE_WIDTH-1:0]  code_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   playing_reg;

    logic    pressed_reg, pressed_next;
    point_t  cur_reg, cur_next;
    point_t  origin_reg, origin_next;

    logic     out_vld_reg, out_vld_next;
    gesture_t gesture_reg, gesture_next;
    logic     down_reg;

    logic     in_accept, advance, is_release;
    gesture_t decided;

    // Handshake: the event stage moves on whenever the result register is empty or being taken.
    assign advance   = !out_vld_reg || !out_stall;
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_vld_next  = in_accept || (in_vld_reg && !advance);
    assign out_vld_next = advance ? in_vld_reg : out_vld_reg;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISP_WIDTH:      cfg_next.disp_width      = cfg_data;
                REG_DISP_HEIGHT:     cfg_next.disp_height     = cfg_data;
                REG_CORNER_SIZE:     cfg_next.corner_size     = cfg_data;
                REG_SWIPE_THRESHOLD: cfg_next.swipe_threshold = cfg_data;
                REG_TAP_RADIUS:      cfg_next.tap_radius      = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Release decision uses the press point and the latest position.
    tgc_decide u_decide (
        .cfg        (cfg_reg),
        .origin     (origin_reg),
        .release_pt (cur_reg),
        .playing    (playing_reg),
        .gesture    (decided)
    );

    assign is_release = (type_reg == EVT_KEY) && (code_reg == CODE_BTN_TOUCH)
                        && (value_reg == '0) && pressed_reg;

    // Touch state update for the event held in the event register.
    always_comb
    begin
        pressed_next = pressed_reg;
        cur_next     = cur_reg;
        origin_next  = origin_reg;
        gesture_next = G_NONE;
        if (type_reg == EVT_ABS && code_reg == CODE_ABS_X)
            cur_next.x = value_reg[COORD_WIDTH-1:0];
        else if (type_reg == EVT_ABS && code_reg == CODE_ABS_Y)
            cur_next.y = value_reg[COORD_WIDTH-1:0];
        else if (type_reg == EVT_KEY && code_reg == CODE_BTN_TOUCH)
        begin
            if (value_reg != '0)
            begin
                if (!pressed_reg)
                begin
                    origin_next  = cur_reg;
                    pressed_next = 1'b1;
                end
            end
            else if (is_release)
            begin
                gesture_next = decided;
                pressed_next = 1'b0;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disp_width      <= RST_DISP_WIDTH;
            cfg_reg.disp_height     <= RST_DISP_HEIGHT;
            cfg_reg.corner_size     <= RST_CORNER_SIZE;
            cfg_reg.swipe_threshold <= RST_SWIPE_THRESHOLD;
            cfg_reg.tap_radius      <= RST_TAP_RADIUS;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pressed_reg <= 1'b0;
            cur_reg     <= '0;
            origin_reg  <= '0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (in_vld_reg && advance)
            begin
                pressed_reg <= pressed_next;
                cur_reg     <= cur_next;
                origin_reg  <= origin_next;
            end
        end
    end

    // Event and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            type_reg    <= event_type;
            code_reg    <= event_code;
            value_reg   <= event_value;
            playing_reg <= playing;
        end
        if (in_vld_reg && advance)
        begin
            gesture_reg <= gesture_next;
            down_reg    <= pressed_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign gesture    = gesture_reg;
    assign touch_down = down_reg;

    `include "touch_gesture_classifier_macros.svh"

    `TGC_ASSERT_SAME(a_gest_released, out_vld_reg && |gesture_reg, !down_reg, "held gesture")
    `TGC_ASSERT_SAME(a_release_drops, in_vld_reg && is_release, !pressed_next, "still pressed")
    `TGC_ASSERT_NEXT(a_stall_holds, !advance, $stable({pressed_reg, origin_reg}), "state moved")
    `TGC_ASSERT_NEXT(a_event_moves, in_vld_reg && advance, out_vld_reg, "event lost")

endmodule

### sim/touch_gesture_classifier_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for touch_gesture_classifier: sends touch events with random
// idling and back-pressure, predicts each gesture result and checks the results in order.
// Depends on tgc_pkg and the touch_gesture_classifier RTL.
module touch_gesture_classifier_tb;
    import tgc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 4;
    localparam int IDLE_PERCENT   = 24;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_TAP_RADIUS + 1'b1;

    typedef struct packed {
        gesture_t gesture;
        logic     touch_down;
    } touch_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [TYPE_WIDTH-1:0]  event_type;
    logic [CODE_WIDTH-1:0]  event_code;
    logic [VALUE_WIDTH-1:0] event_value;
    logic                   playing;
    logic                   out_valid;
    logic                   out_stall;
    logic [GESTURE_W-1:0]   gesture;
    logic                   touch_down;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_WIDTH-1:0]   cfg_data;

    // Tracked copy of the block's registers and touch state.
    cfg_t                   regs;
    logic                   pressed;
    logic [COORD_WIDTH-1:0] cur_x, cur_y, start_x, start_y, last_x, last_y;

    touch_result_t pending_results[$];
    int            mismatches;
    int            events_sent;
    int            results_seen;
    bit            gaps_on;
    bit            stall_on;
    int            hold_request;
    int            hold_left;

    touch_gesture_classifier DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .playing     (playing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .gesture     (gesture),
        .touch_down  (touch_down),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    // Coordinate biased toward the zone and middle-region boundaries.
    function automatic int pick_coord(input int span);
        int c;
        c = int'(regs.corner_size);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, c + 1);
            1: return span - c - 1 + $urandom_range(0, 2);
            2: return c - 1 + $urandom_range(0, 2);
            3: return $urandom;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR [%0t] result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    // Updates the tracked touch state for one accepted event and queues its result.
    task automatic classify_touch_event(input logic [TYPE_WIDTH-1:0] etype,
                                        input logic [CODE_WIDTH-1:0] ecode,
                                        input logic [VALUE_WIDTH-1:0] evalue,
                                        input logic play);
        int            sx, sy, dx, dy, ax, ay, c, rx, by, th;
        bit            horiz, vert, middle;
        gesture_t      g;
        touch_result_t res;
        g  = G_NONE;
        c  = int'(regs.corner_size);
        rx = int'(regs.disp_width) - c;
        by = int'(regs.disp_height) - c;
        th = int'(regs.swipe_threshold);
        if (etype == EVT_ABS && ecode == CODE_ABS_X)
        begin
            cur_x = evalue[COORD_WIDTH-1:0];
        end
        else if (etype == EVT_ABS && ecode == CODE_ABS_Y)
        begin
            cur_y = evalue[COORD_WIDTH-1:0];
        end
        else if (etype == EVT_KEY && ecode == CODE_BTN_TOUCH)
        begin
            if (evalue != '0)
            begin
                // A press latches the start point; a second press is ignored.
                if (!pressed)
                begin
                    start_x = cur_x;
                    start_y = cur_y;
                    last_x  = cur_x;
                    last_y  = cur_y;
                    pressed = 1'b1;
                end
            end
            else if (pressed)
            begin
                last_x = cur_x;
                last_y = cur_y;
                sx = int'(start_x);
                sy = int'(start_y);
                dx = int'(last_x) - sx;
                dy = int'(last_y) - sy;
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                if (ax < int'(regs.tap_radius) && ay < int'(regs.tap_radius))
                begin
                    // Tap: zone of the start point, checked in priority order.
                    if (sx < c && sy < c)
                        g = G_HOME;
                    else if (sx < c && sy > by)
                        g = G_PREV;
                    else if (sx > rx && sy > by)
                        g = G_NEXT;
                    else if (sx > rx && sy < c)
                        g = play ? G_PAUSE : G_NONE;
                    else
                        g = G_TAP_OUTSIDE;
                end
                else if (!play)
                begin
                    g = G_SWIPE_IGNORED;
                end
                else
                begin
                    // Swipe: the main axis must pass the threshold and twice the other axis.
                    horiz  = ax > th && ax > ay * 2;
                    vert   = ay > th && ay > ax * 2;
                    middle = sx >= c && sx <= rx && sy >= c && sy <= by;
                    if (horiz)
                        g = !middle ? G_SWIPE_IGNORED : (dx > 0 ? G_SPEED_UP : G_SPEED_DOWN);
                    else if (vert)
                        g = dy < 0 ? G_VOL_UP : G_VOL_DOWN;
                    else
                        g = G_SWIPE_IGNORED;
                end
                pressed = 1'b0;
            end
        end
        else if (etype == EVT_SYN && ecode == CODE_SYN_REPORT)
        begin
            if (pressed)
            begin
                last_x = cur_x;
                last_y = cur_y;
            end
        end
        res.gesture    = g;
        res.touch_down = pressed;
        pending_results.push_back(res);
    endtask

    // Offers one event, with an optional random gap first, and waits until it is taken.
    task automatic send_event(input logic [TYPE_WIDTH-1:0] etype,
                              input logic [CODE_WIDTH-1:0] ecode,
                              input logic [VALUE_WIDTH-1:0] evalue,
                              input logic play);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        event_type  <= etype;
        event_code  <= ecode;
        event_value <= evalue;
        playing     <= play;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        classify_touch_event(etype, ecode, evalue, play);
        events_sent++;
    endtask

    // Stops sending and waits until every queued result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers, then a spare index that must change nothing.
    task automatic write_geometry(input logic [CFG_WIDTH-1:0] width, height, corner,
                                  input logic [CFG_WIDTH-1:0] threshold, radius);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [CFG_WIDTH-1:0] data [6];
        wait_idle();
        idx  = '{REG_DISP_WIDTH, REG_DISP_HEIGHT, REG_CORNER_SIZE,
                 REG_SWIPE_THRESHOLD, REG_TAP_RADIUS, REG_SPARE};
        data = '{width, height, corner, threshold, radius, 16'($urandom)};
        idx[5] = 3'($urandom_range(int'(REG_SPARE), (1 << CFG_IDX_W) - 1));
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= data[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                REG_DISP_WIDTH:      regs.disp_width      = data[i];
                REG_DISP_HEIGHT:     regs.disp_height     = data[i];
                REG_CORNER_SIZE:     regs.corner_size     = data[i];
                REG_SWIPE_THRESHOLD: regs.swipe_threshold = data[i];
                REG_TAP_RADIUS:      regs.tap_radius      = data[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // One complete touch: position, press, some moves, final position, release.
    task automatic send_stroke();
        int   sx, sy, dx, dy, mag, r, th, ex, ey;
        logic play;
        r    = int'(regs.tap_radius);
        th   = int'(regs.swipe_threshold);
        sx   = pick_coord(int'(regs.disp_width));
        sy   = pick_coord(int'(regs.disp_height));
        play = $urandom_range(0, 3) != 0;
        mag  = th + $urandom_range(0, 200);
        case ($urandom_range(0, 4))
            0:
            begin
                dx = $urandom_range(0, 2 * r) - r;
                dy = $urandom_range(0, 2 * r) - r;
            end
            1:
            begin
                dx = coin() ? mag : -mag;
                dy = $urandom_range(0, mag / 2);
                dy = coin() ? dy : -dy;
            end
            2:
            begin
                dy = coin() ? mag : -mag;
                dx = $urandom_range(0, mag / 2);
                dx = coin() ? dx : -dx;
            end
            3:
            begin
                dx = coin() ? mag : -mag;
                dy = coin() ? mag : -mag;
            end
            default:
            begin
                dx = $urandom_range(0, 65535) - sx;
                dy = $urandom_range(0, 65535) - sy;
            end
        endcase
        ex = sx + dx;
        ey = sy + dy;
        send_event(EVT_ABS, CODE_ABS_X, sx[VALUE_WIDTH-1:0], coin());
        send_event(EVT_ABS, CODE_ABS_Y, sy[VALUE_WIDTH-1:0], coin());
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'($urandom_range(1, 65535)), coin());
        repeat ($urandom_range(0, 2))
        begin
            send_event(EVT_ABS, CODE_ABS_X, 16'($urandom), coin());
            send_event(EVT_SYN, CODE_SYN_REPORT, 16'd0, coin());
        end
        send_event(EVT_ABS, CODE_ABS_X, ex[VALUE_WIDTH-1:0], coin());
        send_event(EVT_ABS, CODE_ABS_Y, ey[VALUE_WIDTH-1:0], coin());
        if (coin())
            send_event(EVT_SYN, CODE_SYN_REPORT, 16'd0, coin());
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, play);
    endtask

    // Mostly complete strokes, with stray key events and random noise mixed in.
    task automatic run_gestures(input int count);
        int                     target;
        logic [TYPE_WIDTH-1:0]  ntype;
        logic [CODE_WIDTH-1:0]  ncode;
        target = events_sent + count;
        while (events_sent < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    ntype = 5'($urandom);
                    ncode = 10'($urandom);
                    if (coin())
                        ntype = coin() ? EVT_SYN : EVT_ABS;
                    if (coin())
                        ncode = coin() ? CODE_ABS_Y : CODE_BTN_TOUCH;
                    send_event(ntype, ncode, 16'($urandom), coin());
                end
                1: send_event(EVT_KEY, CODE_BTN_TOUCH, coin() ? 16'd0 : 16'($urandom), coin());
                default: send_stroke();
            endcase
        end
    endtask

    // Taps in every zone, one swipe, repeated and stray key events, field extremes.
    task automatic test_directed_gestures();
        send_event(EVT_ABS, CODE_ABS_X, 16'd10, 1'b0);
        send_event(EVT_ABS, CODE_ABS_Y, 16'd10, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd1, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b0);
        send_event(EVT_ABS, CODE_ABS_Y, 16'd470, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd1, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b0);
        send_event(EVT_ABS, CODE_ABS_X, 16'd790, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd1, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b0);
        send_event(EVT_ABS, CODE_ABS_Y, 16'd10, 1'b1);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd1, 1'b1);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b1);
        // The top-right tap gives no gesture while the video is paused.
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd1, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b0);
        // Swipe right from the middle, with a second press that must be ignored.
        send_event(EVT_ABS, CODE_ABS_X, 16'd400, 1'b1);
        send_event(EVT_ABS, CODE_ABS_Y, 16'd240, 1'b1);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd1, 1'b1);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd1, 1'b1);
        send_event(EVT_ABS, CODE_ABS_X, 16'd520, 1'b1);
        send_event(EVT_SYN, CODE_SYN_REPORT, 16'd0, 1'b1);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b1);
        // A release with no touch down, then an unknown event.
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b1);
        send_event('1, '1, '1, 1'b1);
        // A full-width drag while paused is an ignored swipe.
        send_event(EVT_ABS, CODE_ABS_X, 16'hFFFF, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'hFFFF, 1'b0);
        send_event(EVT_ABS, CODE_ABS_X, 16'd0, 1'b0);
        send_event(EVT_KEY, CODE_BTN_TOUCH, 16'd0, 1'b0);
    endtask

    task automatic test_default_geometry();
        run_gestures(100);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input;
    // afterwards the sender pauses until every result is back.
    task automatic test_backpressure();
        gaps_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        run_gestures(12);
        gaps_on = 1'b1;
        wait_idle();
    endtask

    // A stretch with no idling on either side.
    task automatic test_steady_stream();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        run_gestures(80);
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // Extreme, oversized-corner and random geometries, ending on the reset values.
    task automatic test_geometry_sweep();
        write_geometry(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
        run_gestures(50);
        write_geometry('1, '1, '1, '1, '1);
        run_gestures(50);
        write_geometry(16'd100, 16'd100, 16'd300, 16'd20, 16'd5);
        run_gestures(50);
        write_geometry(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)),
                       16'($urandom_range(0, 500)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 60)));
        run_gestures(60);
        write_geometry(RST_DISP_WIDTH, RST_DISP_HEIGHT, RST_CORNER_SIZE,
                       RST_SWIPE_THRESHOLD, RST_TAP_RADIUS);
        run_gestures(40);
    endtask

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= stall_on && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Compares each accepted result with the oldest pending one.
    always @(posedge clk)
    begin : result_checker
        touch_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result gesture=%0d touch_down=%0b",
                                          gesture, touch_down));
            end
            else
            begin
                want = pending_results.pop_front();
                if (gesture !== want.gesture)
                    report_mismatch($sformatf("gesture %0d, expected %0d (%s)",
                                              gesture, want.gesture, want.gesture.name()));
                if (touch_down !== want.touch_down)
                    report_mismatch($sformatf("touch_down %0b, expected %0b",
                                              touch_down, want.touch_down));
            end
            results_seen++;
        end
    end

    // Ends the run when nothing moves on any channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        // All inputs start known while reset is held.
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        event_type  <= '0;
        event_code  <= '0;
        event_value <= '0;
        playing     <= 1'b0;
        out_stall   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        gaps_on      = 1'b1;
        stall_on     = 1'b1;
        hold_request = 0;
        hold_left    = 0;
        mismatches   = 0;
        events_sent  = 0;
        results_seen = 0;
        regs = '{RST_DISP_WIDTH, RST_DISP_HEIGHT, RST_CORNER_SIZE,
                 RST_SWIPE_THRESHOLD, RST_TAP_RADIUS};
        pressed = 1'b0;
        cur_x   = '0;
        cur_y   = '0;
        start_x = '0;
        start_y = '0;
        last_x  = '0;
        last_y  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_gestures();
        test_default_geometry();
        test_backpressure();
        test_steady_stream();
        test_geometry_sweep();
        wait_idle();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
